FILE: rtl/core/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// shared constants and types for the longest run with k replacements block
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam int unsigned MaxLen     = 4096;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned SymW       = 5;
  localparam int unsigned PosW       = $clog2(MaxLen);
  localparam int unsigned CntW       = PosW + 1;

  typedef logic [SymW-1:0] sym_t;
  typedef logic [PosW-1:0] pos_t;
  typedef logic [CntW-1:0] cnt_t;

  // request from the window logic to the symbol store
  typedef struct packed {
    logic we;
    pos_t waddr;
    sym_t wdata;
    pos_t raddr;
  } store_req_t;

  // string state seen by the top level
  typedef struct packed {
    pos_t window_start;
    cnt_t symbols_seen;
    cnt_t peak_count;
  } win_status_t;

endpackage

FILE: rtl/core/lrr_symbol_store.sv
// ----------------------------------------------------------------------------
// lrr_symbol_store
// symbol memory, one write and one registered read per cycle, write-first
// ----------------------------------------------------------------------------
module lrr_symbol_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrr_pkg::store_req_t req_i,
  output lrr_pkg::sym_t       rd_sym_o
);

  lrr_pkg::sym_t mem [lrr_pkg::MaxLen];
  lrr_pkg::sym_t rd_raw_q;
  lrr_pkg::sym_t byp_data_q;
  logic          byp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_raw_q   <= mem[req_i.raddr];
    byp_data_q <= req_i.wdata;
  end

  // same-address write forwards the new symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= req_i.we && (req_i.waddr == req_i.raddr);
    end
  end

  assign rd_sym_o = byp_q ? byp_data_q : rd_raw_q;

endmodule

FILE: rtl/core/lrr_window.sv
// ----------------------------------------------------------------------------
// lrr_window
// letter counts, window bounds and peak; one symbol per step
// ----------------------------------------------------------------------------
module lrr_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  lrr_pkg::sym_t        symbol_i,
  input  logic                 first_i,
  input  lrr_pkg::cnt_t        budget_i,
  input  lrr_pkg::sym_t        rd_sym_i,
  output lrr_pkg::store_req_t  store_req_o,
  output lrr_pkg::cnt_t        best_o,
  output lrr_pkg::win_status_t status_o
);

  lrr_pkg::cnt_t cnt_q [lrr_pkg::NumLetters];
  lrr_pkg::cnt_t cnt_d [lrr_pkg::NumLetters];
  lrr_pkg::cnt_t inc   [lrr_pkg::NumLetters];
  lrr_pkg::pos_t ws_q, ws_d, base_ws;
  lrr_pkg::cnt_t seen_q, seen_d, base_seen;
  lrr_pkg::cnt_t peak_q, peak_d, base_peak;
  lrr_pkg::cnt_t sym_cnt, width;
  lrr_pkg::pos_t pos;
  logic [lrr_pkg::CntW:0] reach;
  logic take, shrink;

  always_comb begin
    base_ws   = first_i ? '0 : ws_q;
    base_seen = first_i ? '0 : seen_q;
    base_peak = first_i ? '0 : peak_q;
    take = (symbol_i < lrr_pkg::SymW'(lrr_pkg::NumLetters))
        && (base_seen < lrr_pkg::CntW'(lrr_pkg::MaxLen));
    pos  = base_seen[lrr_pkg::PosW-1:0];

    sym_cnt = '0;
    for (int i = 0; i < lrr_pkg::NumLetters; i++) begin
      inc[i] = (first_i ? '0 : cnt_q[i])
             + lrr_pkg::CntW'(take && (symbol_i == lrr_pkg::SymW'(i)));
      if (symbol_i == lrr_pkg::SymW'(i)) begin
        sym_cnt = inc[i];
      end
    end

    peak_d = (take && (sym_cnt > base_peak)) ? sym_cnt : base_peak;
    reach  = {1'b0, peak_d} + {1'b0, budget_i};
    width  = {1'b0, pos} + lrr_pkg::CntW'(1) - {1'b0, base_ws};
    shrink = take && (reach < {1'b0, width});

    // oldest symbol leaves the window
    for (int i = 0; i < lrr_pkg::NumLetters; i++) begin
      cnt_d[i] = inc[i]
               - lrr_pkg::CntW'(shrink && (rd_sym_i == lrr_pkg::SymW'(i))
                                && (inc[i] != '0));
    end

    ws_d   = shrink ? base_ws + lrr_pkg::PosW'(1) : base_ws;
    seen_d = take ? base_seen + lrr_pkg::CntW'(1) : base_seen;
    best_o = ({1'b0, seen_d} < reach) ? seen_d : reach[lrr_pkg::CntW-1:0];

    store_req_o.we    = step_i && take;
    store_req_o.waddr = pos;
    store_req_o.wdata = symbol_i;
    store_req_o.raddr = step_i ? ws_d : ws_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lrr_pkg::NumLetters; i++) begin
        cnt_q[i] <= '0;
      end
      ws_q   <= '0;
      seen_q <= '0;
      peak_q <= '0;
    end else if (step_i) begin
      cnt_q  <= cnt_d;
      ws_q   <= ws_d;
      seen_q <= seen_d;
      peak_q <= peak_d;
    end
  end

  assign status_o.window_start = ws_q;
  assign status_o.symbols_seen = seen_q;
  assign status_o.peak_count   = peak_q;

endmodule

FILE: rtl/core/longest_run_with_k_replacements.sv
// ----------------------------------------------------------------------------
// longest_run_with_k_replacements
// sliding-window longest single-letter run with a replacement budget
// ----------------------------------------------------------------------------
// path: an accepted beat passes through the input register and then the result
//   register; a full result register that is not drained holds it back
// throughput: one symbol per cycle while out_ready_i does not stall the result;
//   the window update and the symbol store read port handle one symbol each cycle
// reset: counts, window start, symbol count, peak and budget clear at once;
//   the symbol store is not cleared, its entries are written before read
// ----------------------------------------------------------------------------
module longest_run_with_k_replacements (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [12:0]          replace_budget_i,
  // symbol input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [4:0]           symbol_i,
  input  logic                 first_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [12:0]          best_length_o
);

  lrr_pkg::cnt_t        budget_q;
  // input register
  logic                 in_valid_q;
  lrr_pkg::sym_t        sym_q;
  logic                 first_q;
  // result register
  logic                 out_valid_q;
  lrr_pkg::cnt_t        best_q;

  logic                 adv;
  lrr_pkg::store_req_t  store_req;
  lrr_pkg::sym_t        rd_sym;
  lrr_pkg::cnt_t        best_d;
  lrr_pkg::win_status_t status;

  // budget register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      budget_q <= replace_budget_i;
    end
  end

  // held beat moves on when the result register is free or being drained
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers need no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sym_q   <= symbol_i;
      first_q <= first_i;
    end
    if (adv) begin
      best_q <= best_d;
    end
  end

  // window state update, one symbol per step
  lrr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .symbol_i    (sym_q),
    .first_i     (first_q),
    .budget_i    (budget_q),
    .rd_sym_i    (rd_sym),
    .store_req_o (store_req),
    .best_o      (best_d),
    .status_o    (status)
  );

  // stored symbols, read at the window start for the next step
  lrr_symbol_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_sym_o (rd_sym)
  );

  assign out_valid_o   = out_valid_q;
  assign best_length_o = best_q;

  // window never starts past the symbols seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, status.window_start} <= status.symbols_seen)
    else $error("window start beyond symbol count");

  // peak count never exceeds the string length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.peak_count <= status.symbols_seen)
    else $error("peak count beyond symbol count");

  // a held beat that cannot move stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> in_valid_q)
    else $error("held input beat lost");

  // a beat moving into the result register raises the result valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result beat dropped");

endmodule
